/* hdl/hbpw_pkg.sv */
package hbpw_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RUN
  } hbpw_state_e;

  typedef enum logic [1:0] {
    CFG_ENABLE,
    CFG_BACK_BUFFER,
    CFG_BRIGHTNESS,
    CFG_LSB_MSB
  } hbpw_cfg_e;

  localparam int unsigned WordWidth = 16;
  localparam int unsigned BitR1     = 0;
  localparam int unsigned BitG1     = 1;
  localparam int unsigned BitB1     = 2;
  localparam int unsigned BitR2     = 3;
  localparam int unsigned BitG2     = 4;
  localparam int unsigned BitB2     = 5;
  localparam int unsigned AddrLsb   = 9;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned BitLat    = 14;
  localparam int unsigned BitOe     = 15;

endpackage

/* hdl/hub75_bitplane_pixel_writer.sv */
// Channel   Direction  Handshake                 Payload
// pixel     in         start / busy              pixel_x_i, pixel_y_i, red/green/blue_level_i
// result    out        result_valid_o (1 cycle)  buffer_index_o .. last_word_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A pixel transaction makes one read of the scan-word memory per plane, with the
// write-back of each plane on the second port in the cycle after its read.
// Results come from the s2 registers after ST_RUN is entered, one per cycle.
// After reset a clearing pass writes zero to all 2*ceil(H/2)*PLANE_COUNT*W' entries
// (W' is the width rounded up to even), one per cycle, with busy high.
// Dropped pixels give no result; results cannot be stalled.
module hub75_bitplane_pixel_writer #(
  parameter int unsigned PANEL_WIDTH  = 64,
  parameter int unsigned PANEL_HEIGHT = 32,
  parameter int unsigned PLANE_COUNT  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pixel_x_i,
  input  logic signed [15:0] pixel_y_i,
  input  logic [7:0]         red_level_i,
  input  logic [7:0]         green_level_i,
  input  logic [7:0]         blue_level_i,
  output logic               result_valid_o,
  output logic               buffer_index_o,
  output logic [3:0]         panel_row_o,
  output logic [2:0]         plane_index_o,
  output logic [5:0]         stored_column_o,
  output logic [15:0]        scan_word_o,
  output logic               last_word_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i
);
  import hbpw_pkg::*;

  localparam int unsigned HalfRows  = (PANEL_HEIGHT + 1) / 2;
  localparam int unsigned StoreCols = PANEL_WIDTH + (PANEL_WIDTH % 2);
  localparam int unsigned Depth     = 2 * HalfRows * PLANE_COUNT * StoreCols;
  localparam int unsigned AW        = $clog2(Depth);
  localparam int unsigned CW        = $clog2(StoreCols);
  localparam int unsigned RW        = $clog2(HalfRows);
  localparam int unsigned KW        = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  hbpw_state_e state_q, state_d;

  logic       enable_q;
  logic       back_buf_q;
  logic [6:0] brightness_q;
  logic [2:0] lsb_msb_q;

  logic [AW-1:0] clr_cnt_q;
  logic          clr_last;
  logic          clr_we;
  logic          rd_en;
  logic          rd_last;

  logic [15:0]   x_u, y_u, row_full;
  logic          in_range;
  logic          in_top;
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [31:0]   base_full;
  logic          go;

  logic [CW-1:0]          px_x_q;
  logic [RW-1:0]          px_row_q;
  logic                   px_top_q;
  logic                   px_buf_q;
  logic [PLANE_COUNT-1:0] px_red_q, px_green_q, px_blue_q;

  logic [KW-1:0] rd_k_q;
  logic [AW-1:0] rd_addr_q;

  logic          s2_valid_q;
  logic [KW-1:0] s2_k_q;
  logic [AW-1:0] s2_addr_q;
  logic [CW-1:0] s2_x_q;
  logic [RW-1:0] s2_row_q;
  logic          s2_top_q;
  logic          s2_buf_q;
  logic [2:0]    s2_rgb_q;
  logic          s2_fwd_q;
  logic [15:0]   s2_fwd_data_q;

  logic [15:0]          ram_rdata, old_word, word;
  logic [AddrWidth-1:0] row5, row_addr;
  logic [2:0]           k3, frac_shift;
  logic [6:0]           frac;
  logic [15:0]          x16;
  logic                 oe, lat;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      back_buf_q   <= 1'b0;
      brightness_q <= 7'd32;
      lsb_msb_q    <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE:      enable_q     <= cfg_data_i[0];
        CFG_BACK_BUFFER: back_buf_q   <= cfg_data_i[0];
        CFG_BRIGHTNESS:  brightness_q <= cfg_data_i;
        CFG_LSB_MSB:     lsb_msb_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Pixel decode.
  always_comb begin
    x_u       = $unsigned(pixel_x_i);
    y_u       = $unsigned(pixel_y_i);
    in_range  = (x_u < 16'(PANEL_WIDTH)) && (y_u < 16'(PANEL_HEIGHT));
    in_top    = y_u < 16'(HalfRows);
    row_full  = in_top ? y_u : (y_u - 16'(HalfRows));
    in_row    = row_full[RW-1:0];
    in_col    = x_u[CW-1:0] ^ {{(CW-1){1'b0}}, 1'b1};
    base_full = ((32'(back_buf_q) * 32'(HalfRows) + 32'(in_row)) * 32'(PLANE_COUNT))
                * 32'(StoreCols) + 32'(in_col);
  end

  assign clr_last = (clr_cnt_q == AW'(Depth - 1));
  assign rd_last  = (rd_k_q == KW'(PLANE_COUNT - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go) state_d = ST_RUN;
      end
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_RUN: begin
        if (rd_last) state_d = go ? ST_RUN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy   = 1'b1;
    rd_en  = 1'b0;
    clr_we = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
      end
      ST_RUN: begin
        rd_en = 1'b1;
        busy  = !rd_last;
      end
      default: ;
    endcase
  end

  assign go = start && !busy && enable_q && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      rd_k_q     <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s2_valid_q <= rd_en;
      if (clr_we) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (go) begin
        rd_k_q <= '0;
      end else if (rd_en) begin
        rd_k_q <= rd_k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      px_x_q     <= x_u[CW-1:0];
      px_row_q   <= in_row;
      px_top_q   <= in_top;
      px_buf_q   <= back_buf_q;
      px_red_q   <= red_level_i[PLANE_COUNT-1:0];
      px_green_q <= green_level_i[PLANE_COUNT-1:0];
      px_blue_q  <= blue_level_i[PLANE_COUNT-1:0];
      rd_addr_q  <= base_full[AW-1:0];
    end else if (rd_en) begin
      rd_addr_q  <= rd_addr_q + AW'(StoreCols);
    end
    if (rd_en) begin
      s2_k_q        <= rd_k_q;
      s2_addr_q     <= rd_addr_q;
      s2_x_q        <= px_x_q;
      s2_row_q      <= px_row_q;
      s2_top_q      <= px_top_q;
      s2_buf_q      <= px_buf_q;
      s2_rgb_q      <= {px_blue_q[rd_k_q], px_green_q[rd_k_q], px_red_q[rd_k_q]};
      s2_fwd_q      <= s2_valid_q && (s2_addr_q == rd_addr_q);
      s2_fwd_data_q <= word;
    end
  end

  // The write-back of the previous plane may target the entry being read.
  always_comb begin
    old_word   = s2_fwd_q ? s2_fwd_data_q : ram_rdata;
    row5       = AddrWidth'(s2_row_q);
    row_addr   = (s2_k_q == '0) ? (row5 - AddrWidth'(1)) : row5;
    k3         = 3'(s2_k_q);
    x16        = 16'(s2_x_q);
    frac_shift = lsb_msb_q - k3 + 3'd1;
    frac       = brightness_q >> frac_shift;
    lat        = (x16 == 16'(PANEL_WIDTH - 1));
    oe         = (x16 == 16'd0) || (x16 == 16'(PANEL_WIDTH - 2))
              || (((k3 > lsb_msb_q) || (k3 == 3'd0)) && (x16 >= 16'(brightness_q)))
              || ((k3 != 3'd0) && (k3 <= lsb_msb_q) && (x16 >= 16'(frac)));
    word                           = '0;
    word[AddrLsb +: AddrWidth]     = row_addr;
    word[BitLat]                   = lat;
    word[BitOe]                    = oe;
    if (s2_top_q) begin
      word[BitR1] = s2_rgb_q[0];
      word[BitG1] = s2_rgb_q[1];
      word[BitB1] = s2_rgb_q[2];
      word[BitR2] = old_word[BitR2];
      word[BitG2] = old_word[BitG2];
      word[BitB2] = old_word[BitB2];
    end else begin
      word[BitR2] = s2_rgb_q[0];
      word[BitG2] = s2_rgb_q[1];
      word[BitB2] = s2_rgb_q[2];
      word[BitR1] = old_word[BitR1];
      word[BitG1] = old_word[BitG1];
      word[BitB1] = old_word[BitB1];
    end
  end

  assign ram_we    = clr_we || s2_valid_q;
  assign ram_waddr = clr_we ? clr_cnt_q : s2_addr_q;
  assign ram_wdata = clr_we ? '0 : word;

  hbpw_ram #(
    .WIDTH(WordWidth),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr_q),
    .rdata_o(ram_rdata)
  );

  assign result_valid_o  = s2_valid_q;
  assign buffer_index_o  = s2_buf_q;
  assign panel_row_o     = row5[3:0];
  assign plane_index_o   = k3;
  assign stored_column_o = 6'(s2_x_q ^ {{(CW-1){1'b0}}, 1'b1});
  assign scan_word_o     = word;
  assign last_word_o     = (s2_k_q == KW'(PLANE_COUNT - 1));

  a_plane_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_word_o |=>
      result_valid_o && (plane_index_o == $past(plane_index_o) + 3'd1))
    else $error("plane sequence broken within a pixel");

  a_plane_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_word_o |=> !result_valid_o || (plane_index_o == 3'd0))
    else $error("new pixel does not start at plane zero");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !result_valid_o && busy)
    else $error("activity during the clearing pass");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (state_q == ST_RUN) && (rd_k_q == '0))
    else $error("accepted pixel did not start a plane sweep");

endmodule

/* hdl/hbpw_ram.sv */
module hbpw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* verif/hub75_bitplane_pixel_writer_tb.sv */
module hub75_bitplane_pixel_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbpw_pkg::*;

  localparam int PanelW     = 64;
  localparam int PanelH     = 32;
  localparam int Planes     = 8;
  localparam int HalfRows   = (PanelH + 1) / 2;
  localparam int StoreCols  = PanelW + (PanelW % 2);
  localparam int StoreDepth = 2 * HalfRows * Planes * StoreCols;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    bit                 drain;
  } pixel_req_t;

  typedef struct {
    bit          fb;
    logic [3:0]  row;
    logic [2:0]  plane;
    logic [5:0]  col;
    logic [15:0] word;
    bit          last;
  } scan_write_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] pixel_x = '0;
  logic signed [15:0] pixel_y = '0;
  logic [7:0]         red_level = '0;
  logic [7:0]         green_level = '0;
  logic [7:0]         blue_level = '0;
  logic               result_valid;
  logic               buffer_index;
  logic [3:0]         panel_row;
  logic [2:0]         plane_index;
  logic [5:0]         stored_column;
  logic [15:0]        scan_word;
  logic               last_word;
  logic               cfg_we = 1'b0;
  hbpw_cfg_e          cfg_idx = CFG_ENABLE;
  logic [6:0]         cfg_data = '0;

  pixel_req_t  pending_pixels[$];
  pixel_req_t  cur_req;
  scan_write_t scan_expect[$];
  bit [15:0]   frame_model[StoreDepth];
  bit          pix_taken = 1'b0;
  int          idle_pct = 0;
  int          mismatches = 0;

  bit          cfg_en = 1'b0;
  bit          cfg_back = 1'b0;
  bit [6:0]    cfg_bright = 7'd32;
  bit [2:0]    cfg_trans = 3'd0;

  hub75_bitplane_pixel_writer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .red_level_i    (red_level),
    .green_level_i  (green_level),
    .blue_level_i   (blue_level),
    .result_valid_o (result_valid),
    .buffer_index_o (buffer_index),
    .panel_row_o    (panel_row),
    .plane_index_o  (plane_index),
    .stored_column_o(stored_column),
    .scan_word_o    (scan_word),
    .last_word_o    (last_word),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  function automatic void predict_pixel_writes(pixel_req_t p);
    int          xs;
    int          ys;
    int          row;
    int          col;
    int          idx;
    bit          top;
    bit [4:0]    addr;
    bit [15:0]   v;
    bit [15:0]   old;
    int          frac;
    scan_write_t w;
    xs = int'(p.x);
    ys = int'(p.y);
    if (!cfg_en) return;
    if (xs < 0 || ys < 0 || xs >= PanelW || ys >= PanelH) return;
    row = ys;
    top = 1'b1;
    if (row >= HalfRows) begin
      row -= HalfRows;
      top = 1'b0;
    end
    col = xs ^ 1;
    for (int k = 0; k < Planes; k++) begin
      addr = (k == 0) ? 5'(row - 1) : 5'(row);
      idx = ((int'(cfg_back) * HalfRows + row) * Planes + k) * StoreCols + col;
      old = frame_model[idx];
      v = '0;
      v[AddrLsb +: AddrWidth] = addr;
      if (xs == 0) v[BitOe] = 1'b1;
      if (xs == PanelW - 1) v[BitLat] = 1'b1;
      if (xs == PanelW - 2) v[BitOe] = 1'b1;
      if ((k > int'(cfg_trans) || k == 0) && xs >= int'(cfg_bright)) v[BitOe] = 1'b1;
      if (k != 0 && k <= int'(cfg_trans)) begin
        frac = int'(cfg_bright) >> (int'(cfg_trans) - k + 1);
        if (xs >= frac) v[BitOe] = 1'b1;
      end
      if (top) begin
        v[BitR1] = p.r[k];
        v[BitG1] = p.g[k];
        v[BitB1] = p.b[k];
        v[BitR2] = old[BitR2];
        v[BitG2] = old[BitG2];
        v[BitB2] = old[BitB2];
      end else begin
        v[BitR2] = p.r[k];
        v[BitG2] = p.g[k];
        v[BitB2] = p.b[k];
        v[BitR1] = old[BitR1];
        v[BitG1] = old[BitG1];
        v[BitB1] = old[BitB1];
      end
      frame_model[idx] = v;
      w.fb    = cfg_back;
      w.row   = 4'(row);
      w.plane = 3'(k);
      w.col   = 6'(col);
      w.word  = v;
      w.last  = (k == Planes - 1);
      scan_expect.push_back(w);
    end
  endfunction

  // A transaction is accepted at the edge where start is high and busy is low.
  always @(posedge clk_i) begin : monitor
    scan_write_t want;
    pix_taken <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) predict_pixel_writes(cur_req);
    if (rst_ni && result_valid) begin
      if (scan_expect.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected scan word: fb=%0d row=%0d plane=%0d col=%0d word=%h last=%0d",
                   buffer_index, panel_row, plane_index, stored_column, scan_word, last_word);
        mismatches++;
      end else begin
        want = scan_expect.pop_front();
        if (buffer_index !== want.fb || panel_row !== want.row || plane_index !== want.plane ||
            stored_column !== want.col || scan_word !== want.word || last_word !== want.last) begin
          if (mismatches < 10)
            $display("scan word mismatch: exp fb=%0d row=%0d plane=%0d col=%0d word=%h last=%0d",
                     want.fb, want.row, want.plane, want.col, want.word, want.last,
                     ", got fb=%0d row=%0d plane=%0d col=%0d word=%h last=%0d",
                     buffer_index, panel_row, plane_index, stored_column, scan_word,
                     last_word);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    pixel_req_t nxt;
    bit         go;
    if (rst_ni && (!start || pix_taken)) begin
      go = 1'b0;
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        if (!pending_pixels[0].drain || scan_expect.size() == 0) go = 1'b1;
      end
      if (go) begin
        nxt = pending_pixels.pop_front();
        cur_req     <= nxt;
        pixel_x     <= nxt.x;
        pixel_y     <= nxt.y;
        red_level   <= nxt.r;
        green_level <= nxt.g;
        blue_level  <= nxt.b;
      end
      start <= go;
    end
  end

  task automatic add_pixel(int x, int y, int r, int g, int b, bit drain = 1'b0);
    pixel_req_t p;
    p.x     = 16'(x);
    p.y     = 16'(y);
    p.r     = 8'(r);
    p.g     = 8'(g);
    p.b     = 8'(b);
    p.drain = drain;
    pending_pixels.push_back(p);
  endtask

  task automatic add_random_pixel();
    int sel;
    int x;
    int y;
    int r;
    int g;
    int b;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      // Small region so that both half-panels of one word are revisited often.
      x = $urandom_range(0, 3);
      y = $urandom_range(0, 1) * HalfRows + $urandom_range(0, 1);
    end else if (sel < 80) begin
      x = $urandom_range(0, PanelW - 1);
      y = $urandom_range(0, PanelH - 1);
    end else if (sel < 90) begin
      x = $urandom_range(0, 65535);
      y = $urandom_range(0, 65535);
    end else begin
      case ($urandom_range(0, 3))
        0: x = -1;
        1: x = PanelW;
        2: x = 0;
        default: x = PanelW - 1;
      endcase
      case ($urandom_range(0, 3))
        0: y = -1;
        1: y = PanelH;
        2: y = 0;
        default: y = PanelH - 1;
      endcase
    end
    r = $urandom_range(0, 255);
    g = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    if ($urandom_range(0, 9) == 0) r = 0;
    if ($urandom_range(0, 9) == 0) g = 255;
    add_pixel(x, y, r, g, b, $urandom_range(0, 49) == 0);
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || start || scan_expect.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reg(hbpw_cfg_e idx, logic [6:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_ENABLE:      cfg_en = data[0];
      CFG_BACK_BUFFER: cfg_back = data[0];
      CFG_BRIGHTNESS:  cfg_bright = data;
      CFG_LSB_MSB:     cfg_trans = data[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(bit en, bit fb, int bright, int trans);
    wait_idle();
    write_reg(CFG_ENABLE, 7'(en));
    write_reg(CFG_BACK_BUFFER, 7'(fb));
    write_reg(CFG_BRIGHTNESS, 7'(bright));
    write_reg(CFG_LSB_MSB, 7'(trans));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : timeout
    #2_000_000;
    $display("FAIL hub75_bitplane_pixel_writer");
    $finish;
  end

  initial begin : stimulus
    int bright_tab[9];
    int trans_tab[9];
    int idle_tab[9];
    bright_tab = '{0, 64, 127, 32, 0, 1, 63, 0, 64};
    trans_tab  = '{0, 7, 7, 3, 0, 1, 6, 0, 0};
    idle_tab   = '{0, 80, 0, 16, 0, 80, 16, 0, 80};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Writes while disabled must be dropped.
    add_pixel(5, 5, 255, 255, 255);
    add_pixel(0, 0, 1, 2, 3);
    set_config(1'b1, 1'b0, 32, 2);

    add_pixel(0, 0, 255, 0, 8'hAA);
    add_pixel(0, 16, 0, 255, 8'h55);
    add_pixel(PanelW - 1, PanelH - 1, 255, 255, 255);
    add_pixel(PanelW - 2, HalfRows - 1, 8'h0F, 8'hF0, 8'h81);
    add_pixel(1, 1, 8'h80, 8'h01, 8'h7F);
    add_pixel(31, 5, 8'h12, 8'h34, 8'h56);
    add_pixel(32, 5, 8'h65, 8'h43, 8'h21);
    add_pixel(7, 3, 8'hC3, 8'h3C, 8'h99);
    add_pixel(8, 3, 8'h3C, 8'hC3, 8'h66);
    add_pixel(15, 20, 8'hFF, 8'h00, 8'hFF);
    add_pixel(16, 20, 8'h00, 8'hFF, 8'h00, 1'b1);
    add_pixel(-1, 0, 255, 255, 255);
    add_pixel(PanelW, 0, 255, 255, 255);
    add_pixel(0, -1, 255, 255, 255);
    add_pixel(0, PanelH, 255, 255, 255);
    add_pixel(-32768, -32768, 255, 255, 255);
    add_pixel(32767, 32767, 255, 255, 255);
    add_pixel(16'h4000, 5, 255, 255, 255);
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(0, 16, 0, 0, 0);

    for (int p = 0; p < 9; p++) begin
      if (p == 4) bright_tab[p] = $urandom_range(0, 127);
      if (p == 7) bright_tab[p] = $urandom_range(0, 127);
      if (p == 4) trans_tab[p] = $urandom_range(0, 7);
      if (p == 7) trans_tab[p] = $urandom_range(0, 7);
      set_config(p != 4, 1'(p % 2), bright_tab[p], trans_tab[p]);
      idle_pct = idle_tab[p];
      for (int i = 0; i < ((p == 4) ? 10 : 60); i++) add_random_pixel();
    end

    while (pending_pixels.size() != 0 || start || scan_expect.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && scan_expect.size() == 0) begin
      $display("PASS hub75_bitplane_pixel_writer");
    end else begin
      $display("FAIL hub75_bitplane_pixel_writer");
    end
    $finish;
  end

endmodule
